[rtl/core/mos_pkg.sv]
package mos_pkg;

    localparam int SAMPLE_W = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

[rtl/core/mos_ram.sv]
module mos_ram #(
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  mos_pkg::sample_t   wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output mos_pkg::sample_t   rd_data
);

    mos_pkg::sample_t mem [DEPTH];
    mos_pkg::sample_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/median_of_samples_unit.sv]
// Median of a set of signed Q16.16 samples. Each accepted word is inserted in
// ascending order into a simple dual-port store (one write and one read per
// cycle, read data registered); the word flagged is_last closes the set and
// one result word follows with the middle sample, or the floor mean of the two
// middle samples for an even count. An insert into an empty store is a single
// write; otherwise each held sample larger than the new one is read and moved
// up one place before the new one is written, and this shifting walk through
// the store sets the rate. The closing word reads the middle sample (odd count)
// or both middle samples (even count) before the result is presented. Samples
// arriving with the store full are dropped and the result reports overflowed.
// A new word is taken while an earlier result waits.
module median_of_samples_unit #(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mos_pkg::sample_t s_sample,
    input  logic             s_is_last,
    output logic             m_valid,
    input  logic             m_ready,
    output mos_pkg::sample_t m_median_value,
    output logic             m_overflowed
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_MED_RD,
        ST_MED_LO,
        ST_MED_HI,
        ST_OUT
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic             ovf_reg;
    logic [AW-1:0]    pos_reg;
    logic             last_reg;
    mos_pkg::sample_t sample_reg;
    mos_pkg::sample_t lo_reg;
    mos_pkg::sample_t med_reg;
    logic             m_valid_reg;
    mos_pkg::sample_t m_median_value_reg;
    logic             m_overflowed_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    mos_pkg::sample_t wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    mos_pkg::sample_t rd_data;

    logic             full;
    logic             empty;
    logic [AW-1:0]    mid;
    logic             greater;
    logic [mos_pkg::SAMPLE_W:0] pair_sum;

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign mid      = AW'(count_reg >> 1);
    assign greater  = (rd_data > sample_reg);
    assign pair_sum = {lo_reg[mos_pkg::SAMPLE_W-1], lo_reg}
                    + {rd_data[mos_pkg::SAMPLE_W-1], rd_data};

    mos_ram #(
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // store access per state
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = sample_reg;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (empty) begin
                        wr_en   = 1'b1;
                        wr_data = s_sample;
                    end else if (!full) begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(count_reg - CW'(1));
                    end
                end
            end
            ST_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (greater) begin
                    wr_data = rd_data;
                    if (pos_reg != AW'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - AW'(2);
                    end
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
            end
            ST_MED_RD: begin
                rd_en   = 1'b1;
                rd_addr = count_reg[0] ? mid : mid - AW'(1);
            end
            ST_MED_LO: begin
                if (!count_reg[0]) begin
                    rd_en   = 1'b1;
                    rd_addr = mid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample;
                        last_reg   <= s_is_last;
                        if (full) begin
                            ovf_reg <= 1'b1;
                            if (s_is_last) begin
                                state_reg <= ST_MED_RD;
                            end
                        end else if (empty) begin
                            count_reg <= CW'(1);
                            if (s_is_last) begin
                                state_reg <= ST_MED_RD;
                            end
                        end else begin
                            pos_reg   <= AW'(count_reg);
                            state_reg <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT: begin
                    if (greater) begin
                        pos_reg <= pos_reg - AW'(1);
                        if (pos_reg == AW'(1)) begin
                            state_reg <= ST_PLACE;
                        end
                    end else begin
                        count_reg <= count_reg + CW'(1);
                        state_reg <= last_reg ? ST_MED_RD : ST_IDLE;
                    end
                end
                ST_PLACE: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= last_reg ? ST_MED_RD : ST_IDLE;
                end
                ST_MED_RD: begin
                    state_reg <= ST_MED_LO;
                end
                ST_MED_LO: begin
                    if (count_reg[0]) begin
                        med_reg   <= rd_data;
                        state_reg <= ST_OUT;
                    end else begin
                        lo_reg    <= rd_data;
                        state_reg <= ST_MED_HI;
                    end
                end
                ST_MED_HI: begin
                    med_reg   <= pair_sum[mos_pkg::SAMPLE_W:1];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_median_value_reg <= med_reg;
                        m_overflowed_reg   <= ovf_reg;
                        count_reg          <= '0;
                        ovf_reg            <= 1'b0;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_median_value = m_median_value_reg;
    assign m_overflowed   = m_overflowed_reg;

endmodule
